@@ hw/rtl/bpa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and status codes of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam logic [2:0] ST_GRANTED  = 3'd0;
	localparam logic [2:0] ST_POOL     = 3'd1;
	localparam logic [2:0] ST_FREED    = 3'd2;
	localparam logic [2:0] ST_BAD_IDX  = 3'd3;
	localparam logic [2:0] ST_NOT_ALLOC = 3'd4;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic {
		OUT_EMPTY,
		OUT_HOLD
	} ctrl_state_t;

	typedef struct packed {
		logic load;
	} bpa_cmd_t;

endpackage
`default_nettype wire

@@ hw/rtl/bpa_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_ctrl
// Handshake controller: tracks the output register and issues the load
// command that commits one request per transfer.
// ----------------------------------------------------------------------------
module bpa_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output      logic             in_stall,
	output      logic             out_valid,
	input  wire logic             out_stall,
	output      bpa_pkg::bpa_cmd_t cmd
);

	bpa_pkg::ctrl_state_t state_q;
	bpa_pkg::ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpa_pkg::OUT_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bpa_pkg::OUT_EMPTY: begin
				if (cmd.load) begin
					state_d = bpa_pkg::OUT_HOLD;
				end
			end
			bpa_pkg::OUT_HOLD: begin
				if (cmd.load) begin
					state_d = bpa_pkg::OUT_HOLD;
				end else if (!out_stall) begin
					state_d = bpa_pkg::OUT_EMPTY;
				end
			end
			default: begin
				state_d = bpa_pkg::OUT_EMPTY;
			end
		endcase
	end

	always_comb begin
		out_valid = 1'b0;
		in_stall  = 1'b0;
		case (state_q)
			bpa_pkg::OUT_EMPTY: begin
				out_valid = 1'b0;
				in_stall  = 1'b0;
			end
			bpa_pkg::OUT_HOLD: begin
				out_valid = 1'b1;
				in_stall  = out_stall;
			end
			default: begin
				out_valid = 1'b0;
				in_stall  = 1'b0;
			end
		endcase
		cmd.load = in_valid && !in_stall;
	end

endmodule
`default_nettype wire

@@ hw/rtl/bpa_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_dp
// Datapath: free map register, priority encoder, free-index check and the
// output result register.
// ----------------------------------------------------------------------------
module bpa_dp #(
	parameter int PAGES      = 64,
	parameter int PAGE_SHIFT = 12
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bpa_pkg::bpa_cmd_t cmd,
	input  wire logic              kind,
	input  wire logic [31:0]       page_offset,
	output      logic [2:0]        status,
	output      logic [5:0]        page_index,
	output      logic              needs_clear,
	output      logic              now_full,
	output      logic              now_free
);

	localparam int IW = $clog2(PAGES);
	localparam logic [IW-1:0] LAST = IW'(PAGES - 1);

	logic [PAGES-1:0] map_q;
	logic [PAGES-1:0] map_d;
	logic [IW-1:0]    top_pos;
	logic [IW-1:0]    grant_idx;
	logic [PAGES-1:0] map_alloc;
	logic [31:0]      off_idx;
	logic             in_range;
	logic [IW-1:0]    free_pos;
	logic [PAGES-1:0] map_freed;

	logic [2:0] status_d;
	logic [5:0] index_d;
	logic       clr_d;
	logic       full_d;
	logic       freed_d;

	// highest set bit = lowest numbered free page
	always_comb begin
		top_pos = '0;
		for (int i = 0; i < PAGES; i++) begin
			if (map_q[i]) begin
				top_pos = IW'(i);
			end
		end
	end

	assign grant_idx = LAST - top_pos;
	assign off_idx   = page_offset >> PAGE_SHIFT;
	assign in_range  = off_idx < 32'(PAGES);
	assign free_pos  = LAST - off_idx[IW-1:0];

	always_comb begin
		map_alloc = map_q;
		map_alloc[top_pos] = 1'b0;
		map_freed = map_q;
		map_freed[free_pos] = 1'b1;
	end

	always_comb begin
		map_d    = map_q;
		status_d = bpa_pkg::ST_GRANTED;
		index_d  = '0;
		clr_d    = 1'b0;
		full_d   = 1'b0;
		freed_d  = 1'b0;
		if (kind == bpa_pkg::KIND_ALLOC) begin
			if (map_q == '0) begin
				status_d = bpa_pkg::ST_POOL;
			end else begin
				status_d = bpa_pkg::ST_GRANTED;
				index_d  = 6'(grant_idx);
				clr_d    = grant_idx != '0;
				full_d   = map_alloc == '0;
				map_d    = map_alloc;
			end
		end else begin
			if (!in_range) begin
				status_d = bpa_pkg::ST_BAD_IDX;
			end else begin
				index_d = 6'(off_idx[IW-1:0]);
				if (map_q[free_pos]) begin
					status_d = bpa_pkg::ST_NOT_ALLOC;
				end else begin
					status_d = bpa_pkg::ST_FREED;
					freed_d  = map_q == '0;
					map_d    = map_freed;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= '1;
		end else if (cmd.load) begin
			map_q <= map_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status      <= status_d;
			page_index  <= index_d;
			needs_clear <= clr_d;
			now_full    <= full_d;
			now_free    <= freed_d;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/bitmap_page_allocator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// Page allocator for one bucket: a free map of PAGES bits, allocate grants
// the lowest numbered free page, free returns a page given by byte offset.
//
// Input channel (in_valid/in_stall): kind and page_offset; one transfer is
// one request. Output channel (out_valid/out_stall): status, page_index,
// needs_clear, now_full, now_free; exactly one result per request.
// The result is registered and is valid the cycle after the input transfer.
// One request per cycle while in_stall is low; the encoder, the index check
// and the map update are combinational and complete in the transfer cycle.
// A result waits in the output register while out_stall is high; in that
// case in_stall is raised and no new request is taken until it moves.
// A new request is taken in the same cycle the held result transfers.
// Reset (arst_n low) marks every page free and empties the output register.
// ----------------------------------------------------------------------------
module bitmap_page_allocator #(
	parameter int PAGES      = 64,
	parameter int PAGE_SHIFT = 12
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic        kind,
	input  wire logic [31:0] page_offset,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [2:0]  status,
	output      logic [5:0]  page_index,
	output      logic        needs_clear,
	output      logic        now_full,
	output      logic        now_free
);

	bpa_pkg::bpa_cmd_t cmd;

	bpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	bpa_dp #(
		.PAGES      (PAGES),
		.PAGE_SHIFT (PAGE_SHIFT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.kind        (kind),
		.page_offset (page_offset),
		.status      (status),
		.page_index  (page_index),
		.needs_clear (needs_clear),
		.now_full    (now_full),
		.now_free    (now_free)
	);

endmodule
`default_nettype wire
